>>> hdl/fav_pkg.sv
// Shared widths, register indexes, reset values and types of the frustum visibility test.
`default_nettype none

package fav_pkg;

    localparam int COORD_W      = 32;
    localparam int ENTRY_W      = 16;
    localparam int TERM_W       = ENTRY_W + 1;
    localparam int PROD_W       = TERM_W + COORD_W;
    localparam int PART_W       = PROD_W + 1;
    localparam int DIST_W       = PART_W + 1;
    localparam int ROW_W        = 4 * ENTRY_W;
    localparam int ROW_COUNT    = 4;
    localparam int AXIS_COUNT   = 3;
    localparam int PLANE_COUNT  = 2 * AXIS_COUNT;
    localparam int OFFSET_SHIFT = 16;
    localparam int CFG_IDX_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE = CFG_IDX_W'(3);

    localparam logic [ROW_W-1:0] ROW_ZERO_RESET  = 64'h0000_0000_0000_0100;
    localparam logic [ROW_W-1:0] ROW_ONE_RESET   = 64'h0000_0000_0100_0000;
    localparam logic [ROW_W-1:0] ROW_TWO_RESET   = 64'h0000_0100_0000_0000;
    localparam logic [ROW_W-1:0] ROW_THREE_RESET = 64'h0100_0000_0000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TERM_W-1:0]  term_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef struct packed {
        logic part_valid;
        logic out_valid;
    } sum_status_t;

endpackage

`default_nettype wire

>>> hdl/fav_plane_cfg.sv
// Matrix registers and the six unnormalised frustum planes derived from them.
`default_nettype none

module fav_plane_cfg
    import fav_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_enable,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_W-1:0]     cfg_data,
    output term_t                     normal [PLANE_COUNT][AXIS_COUNT],
    output term_t                     offset [PLANE_COUNT]
);

    logic [ROW_W-1:0] row_reg  [ROW_COUNT];
    logic [ROW_W-1:0] row_next [ROW_COUNT];

    always_comb
    begin
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            row_next[r] = row_reg[r];
        end
        if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_ROW_ZERO:  row_next[0] = cfg_data;
                REG_ROW_ONE:   row_next[1] = cfg_data;
                REG_ROW_TWO:   row_next[2] = cfg_data;
                REG_ROW_THREE: row_next[3] = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_ZERO_RESET;
            row_reg[1] <= ROW_ONE_RESET;
            row_reg[2] <= ROW_TWO_RESET;
            row_reg[3] <= ROW_THREE_RESET;
        end
        else
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                row_reg[r] <= row_next[r];
            end
        end
    end

    // Plane k uses axis k/2; even planes add the axis column, odd planes subtract it.
    always_comb
    begin
        logic signed [ENTRY_W-1:0] w_entry;
        logic signed [ENTRY_W-1:0] a_entry;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                w_entry = $signed(row_reg[i][3*ENTRY_W +: ENTRY_W]);
                a_entry = $signed(row_reg[i][(k/2)*ENTRY_W +: ENTRY_W]);
                if (k % 2 == 1)
                begin
                    normal[k][i] = TERM_W'(w_entry) - TERM_W'(a_entry);
                end
                else
                begin
                    normal[k][i] = TERM_W'(w_entry) + TERM_W'(a_entry);
                end
            end
            w_entry = $signed(row_reg[3][3*ENTRY_W +: ENTRY_W]);
            a_entry = $signed(row_reg[3][(k/2)*ENTRY_W +: ENTRY_W]);
            if (k % 2 == 1)
            begin
                offset[k] = TERM_W'(w_entry) - TERM_W'(a_entry);
            end
            else
            begin
                offset[k] = TERM_W'(w_entry) + TERM_W'(a_entry);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/fav_mul_stage.sv
// First pipeline stage: corner selection and the eighteen plane-coordinate products.
`default_nettype none

module fav_mul_stage
    import fav_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire coord_t min_x,
    input  wire coord_t min_y,
    input  wire coord_t min_z,
    input  wire coord_t max_x,
    input  wire coord_t max_y,
    input  wire coord_t max_z,
    input  wire term_t normal [PLANE_COUNT][AXIS_COUNT],
    input  wire logic  down_ready,
    output logic       ready,
    output logic       mul_valid,
    output prod_t      prod [PLANE_COUNT][AXIS_COUNT]
);

    logic   valid_reg;
    logic   valid_next;
    prod_t  prod_reg  [PLANE_COUNT][AXIS_COUNT];
    prod_t  prod_next [PLANE_COUNT][AXIS_COUNT];
    coord_t lo [AXIS_COUNT];
    coord_t hi [AXIS_COUNT];

    assign ready = !valid_reg || down_ready;
    assign valid_next = ready ? in_valid : valid_reg;

    always_comb
    begin
        lo[0] = min_x;
        lo[1] = min_y;
        lo[2] = min_z;
        hi[0] = max_x;
        hi[1] = max_y;
        hi[2] = max_z;
    end

    // A zero normal component picks the maximum corner.
    always_comb
    begin
        coord_t corner;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                corner = normal[k][i][TERM_W-1] ? lo[i] : hi[i];
                prod_next[k][i] = PROD_W'(normal[k][i]) * PROD_W'(corner);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign mul_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

`default_nettype wire

>>> hdl/fav_sum_stage.sv
// Second and third pipeline stages: partial sums, plane distances and the cull decision.
`default_nettype none

module fav_sum_stage
    import fav_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  mul_valid,
    input  wire prod_t prod [PLANE_COUNT][AXIS_COUNT],
    input  wire term_t offset [PLANE_COUNT],
    input  wire logic  out_stall,
    output logic       ready,
    output logic       out_valid,
    output logic       visible,
    output sum_status_t status
);

    logic                     part_valid_reg;
    logic                     part_valid_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_ready;
    logic signed [PART_W-1:0] part_a_reg  [PLANE_COUNT];
    logic signed [PART_W-1:0] part_b_reg  [PLANE_COUNT];
    logic signed [PART_W-1:0] part_a_next [PLANE_COUNT];
    logic signed [PART_W-1:0] part_b_next [PLANE_COUNT];
    logic                     visible_reg;
    logic                     visible_next;

    assign out_ready       = !out_valid_reg || !out_stall;
    assign ready           = !part_valid_reg || out_ready;
    assign part_valid_next = ready ? mul_valid : part_valid_reg;
    assign out_valid_next  = out_ready ? part_valid_reg : out_valid_reg;

    // The plane offset is brought to the product scale before it is added.
    always_comb
    begin
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            part_a_next[k] = PART_W'(prod[k][0]) + PART_W'(prod[k][1]);
            part_b_next[k] = PART_W'(prod[k][2]) + (PART_W'(offset[k]) <<< OFFSET_SHIFT);
        end
    end

    always_comb
    begin
        logic signed [DIST_W-1:0] plane_dist;
        visible_next = 1'b1;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            plane_dist = DIST_W'(part_a_reg[k]) + DIST_W'(part_b_reg[k]);
            if (plane_dist[DIST_W-1])
            begin
                visible_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            part_valid_reg <= part_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && mul_valid)
        begin
            part_a_reg <= part_a_next;
            part_b_reg <= part_b_next;
        end
        if (out_ready && part_valid_reg)
        begin
            visible_reg <= visible_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign visible           = visible_reg;
    assign status.part_valid = part_valid_reg;
    assign status.out_valid  = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/frustum_aabb_visibility_test_unit.sv
// Top level of the frustum visibility test for axis-aligned boxes.
`default_nettype none

// The unit takes one box per clock cycle while its input is not stalled, and returns the visible
// flag of each accepted box in order after three register stages: the corner products, the partial
// plane sums, and the final distance and cull decision. Each stage holds its item under a stall and
// frees as soon as the next stage takes it, so the input is stalled only when all three stages hold
// an item and the output is stalled. The matrix rows should be written only while no item is in
// flight.
module frustum_aabb_visibility_test_unit
    import fav_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_enable,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire coord_t               min_x,
    input  wire coord_t               min_y,
    input  wire coord_t               min_z,
    input  wire coord_t               max_x,
    input  wire coord_t               max_y,
    input  wire coord_t               max_z,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      visible
);

    term_t       normal [PLANE_COUNT][AXIS_COUNT];
    term_t       offset [PLANE_COUNT];
    prod_t       prod   [PLANE_COUNT][AXIS_COUNT];
    logic        mul_ready;
    logic        mul_valid;
    logic        sum_ready;
    sum_status_t sum_status;

    fav_plane_cfg u_plane_cfg
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .normal           (normal),
        .offset           (offset)
    );

    fav_mul_stage u_mul_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .min_x      (min_x),
        .min_y      (min_y),
        .min_z      (min_z),
        .max_x      (max_x),
        .max_y      (max_y),
        .max_z      (max_z),
        .normal     (normal),
        .down_ready (sum_ready),
        .ready      (mul_ready),
        .mul_valid  (mul_valid),
        .prod       (prod)
    );

    fav_sum_stage u_sum_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mul_valid (mul_valid),
        .prod      (prod),
        .offset    (offset),
        .out_stall (out_stall),
        .ready     (sum_ready),
        .out_valid (out_valid),
        .visible   (visible),
        .status    (sum_status)
    );

    assign in_stall = !mul_ready;

    logic in_take;
    logic out_take;
    logic [2:0] stage_valid;

    assign in_take     = in_valid && !in_stall;
    assign out_take    = out_valid && !out_stall;
    assign stage_valid = {mul_valid, sum_status.part_valid, sum_status.out_valid};

    // The input is held off only when every stage is full and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (mul_valid && sum_status.part_valid && out_valid && out_stall))
        else $error("input stalled while the pipeline had room");

    // An item taken in with none delivered adds exactly one to the occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && !out_take) |=>
            ($countones(stage_valid) == $past($countones(stage_valid)) + 1))
        else $error("accepted item not tracked by the pipeline");

    // A delivered item with none taken in removes exactly one from the occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_take && out_take) |=>
            ($countones(stage_valid) + 1 == $past($countones(stage_valid))))
        else $error("delivered item not retired from the pipeline");

endmodule

`default_nettype wire

>>> dv/tb_frustum_aabb_visibility_test_unit.sv
// Self-checking testbench for the frustum visibility test of axis-aligned boxes.
module tb_frustum_aabb_visibility_test_unit;
    import fav_pkg::*;

    localparam int UNIT = 65536;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RUN_LIMIT = 5_000_000;

    localparam coord_t ONE = 32'sh0001_0000;
    localparam coord_t HALF = 32'sh0000_8000;
    localparam coord_t TWO = 32'sh0002_0000;
    localparam coord_t THREE = 32'sh0003_0000;
    localparam coord_t MOST_NEG = 32'sh8000_0000;
    localparam coord_t MOST_POS = 32'sh7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = REG_ROW_THREE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_enable = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    coord_t               min_x = '0;
    coord_t               min_y = '0;
    coord_t               min_z = '0;
    coord_t               max_x = '0;
    coord_t               max_y = '0;
    coord_t               max_z = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 visible;

    logic [ROW_W-1:0] matrix_rows [ROW_COUNT];
    bit               expected_visible [$];
    bit               wanted_visible;
    int unsigned      mismatch_count = 0;
    int unsigned      hold_off_requests = 0;
    int unsigned      hold_off_served = 0;
    longint unsigned  clock_count = 0;
    bit               sender_gaps = 1'b1;

    frustum_aabb_visibility_test_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .min_x            (min_x),
        .min_y            (min_y),
        .min_z            (min_z),
        .max_x            (max_x),
        .max_y            (max_y),
        .max_z            (max_z),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .visible          (visible)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        clock_count <= clock_count + 1;
    end

    function automatic longint matrix_entry(input int row, input int col);
        return longint'($signed(matrix_rows[row][ENTRY_W*col +: ENTRY_W]));
    endfunction

    // A box is culled as soon as one plane has even the corner farthest along its normal strictly behind it.
    function automatic bit box_visible(input box_t b);
        longint lo [AXIS_COUNT];
        longint hi [AXIS_COUNT];
        longint plane_dist;
        longint normal;
        longint sgn;
        int     axis;
        lo[0] = longint'(b.min_x);
        lo[1] = longint'(b.min_y);
        lo[2] = longint'(b.min_z);
        hi[0] = longint'(b.max_x);
        hi[1] = longint'(b.max_y);
        hi[2] = longint'(b.max_z);
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            axis = k / 2;
            sgn = (k % 2 != 0) ? -1 : 1;
            plane_dist = (matrix_entry(3, 3) + sgn * matrix_entry(3, axis)) <<< OFFSET_SHIFT;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                normal = matrix_entry(i, 3) + sgn * matrix_entry(i, axis);
                plane_dist += normal * ((normal >= 0) ? hi[i] : lo[i]);
            end
            if (plane_dist < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [ENTRY_W-1:0] jitter_entry(input int reach);
        return ENTRY_W'(int'($urandom_range(0, 2 * reach)) - reach);
    endfunction

    function automatic logic [ROW_W-1:0] pack_row(input logic [ENTRY_W-1:0] e0,
                                                  input logic [ENTRY_W-1:0] e1,
                                                  input logic [ENTRY_W-1:0] e2,
                                                  input logic [ENTRY_W-1:0] e3);
        return {e3, e2, e1, e0};
    endfunction

    // Mostly well-formed boxes around the origin (or a z centre), some inverted on any of their axes,
    // and some with every field fully random.
    function automatic box_t random_box(input int span, input int z_centre);
        box_t        b;
        coord_t      lo [AXIS_COUNT];
        coord_t      hi [AXIS_COUNT];
        coord_t      swap;
        int          centre;
        int          half_size;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        for (int a = 0; a < AXIS_COUNT; a++)
        begin
            if (pick < 15)
            begin
                lo[a] = $urandom;
                hi[a] = $urandom;
            end
            else
            begin
                centre = int'($urandom_range(0, 2 * span * UNIT)) - span * UNIT;
                if (a == 2)
                    centre += z_centre * UNIT;
                half_size = int'($urandom_range(0, span * UNIT / 2));
                lo[a] = centre - half_size;
                hi[a] = centre + half_size;
                if (pick < 23 && $urandom_range(0, 2) == 0)
                begin
                    swap = lo[a];
                    lo[a] = hi[a];
                    hi[a] = swap;
                end
            end
        end
        b.min_x = lo[0];
        b.min_y = lo[1];
        b.min_z = lo[2];
        b.max_x = hi[0];
        b.max_y = hi[1];
        b.max_z = hi[2];
        return b;
    endfunction

    task automatic send_box(input box_t b);
        int unsigned gap;
        in_valid <= 1'b1;
        min_x <= b.min_x;
        min_y <= b.min_y;
        min_z <= b.min_z;
        max_x <= b.max_x;
        max_y <= b.max_y;
        max_z <= b.max_z;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        expected_visible.push_back(box_visible(b));
        gap = sender_gaps ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_visible.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_row(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        if (idx <= REG_ROW_THREE)
            matrix_rows[idx] = data;
        @(posedge clk);
    endtask

    task automatic load_matrix(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                               input logic [ROW_W-1:0] r2, input logic [ROW_W-1:0] r3);
        write_row(REG_ROW_ZERO, r0);
        write_row(REG_ROW_ONE, r1);
        write_row(REG_ROW_TWO, r2);
        write_row(REG_ROW_THREE, r3);
    endtask

    task automatic run_random_boxes(input int count, input int span, input int z_centre);
        for (int n = 0; n < count; n++)
        begin
            sender_gaps = ((n / 80) % 4) != 3;
            send_box(random_box(span, z_centre));
        end
        wait_idle();
    endtask

    // With the identity matrix after reset the frustum is the cube from -1 to +1.
    task automatic test_reset_identity();
        send_box(box_t'{-ONE, -ONE, -ONE, ONE, ONE, ONE});
        send_box(box_t'{TWO, -HALF, -HALF, THREE, HALF, HALF});
        wait_idle();
    endtask

    task automatic test_boundary_boxes();
        // Touching the left plane exactly, then one step beyond it.
        send_box(box_t'{-THREE, -HALF, -HALF, -ONE, HALF, HALF});
        send_box(box_t'{-THREE, -HALF, -HALF, coord_t'(-ONE - 1), HALF, HALF});
        // Minimum above maximum is used as given.
        send_box(box_t'{TWO, TWO, TWO, -TWO, -TWO, -TWO});
        send_box(box_t'{HALF, HALF, HALF, -HALF, -HALF, -HALF});
        send_box(box_t'{MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG});
        send_box(box_t'{MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS});
        send_box(box_t'{MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS});
        send_box(box_t'{MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG});
        send_box(box_t'{'0, '0, '0, '0, '0, '0});
        send_box(box_t'{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                        32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555});
        wait_idle();
    endtask

    task automatic test_matrix_extremes();
        logic [ROW_W-1:0] extremes [4];
        extremes[0] = {4{16'h8000}};
        extremes[1] = {4{16'h7FFF}};
        extremes[2] = '0;
        extremes[3] = {4{16'hFFFF}};
        // Writes beyond the last row must leave the matrix untouched.
        write_row(REG_UNUSED_LOW, '0);
        write_row(REG_UNUSED_TOP, '0);
        send_box(box_t'{TWO, TWO, TWO, THREE, THREE, THREE});
        wait_idle();
        for (int s = 0; s < 4; s++)
        begin
            load_matrix(extremes[s], extremes[s], extremes[s], extremes[s]);
            send_box(box_t'{-ONE, -ONE, -ONE, ONE, ONE, ONE});
            send_box(box_t'{MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS});
            send_box(box_t'{MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG});
            wait_idle();
        end
    endtask

    task automatic test_random_frusta();
        load_matrix(ROW_ZERO_RESET, ROW_ONE_RESET, ROW_TWO_RESET, ROW_THREE_RESET);
        run_random_boxes(320, 3, 0);

        load_matrix(pack_row(ENTRY_W'($urandom_range(64, 768)), jitter_entry(64),
                             jitter_entry(64), jitter_entry(32)),
                    pack_row(jitter_entry(64), ENTRY_W'($urandom_range(64, 768)),
                             jitter_entry(64), jitter_entry(32)),
                    pack_row(jitter_entry(64), jitter_entry(64),
                             ENTRY_W'($urandom_range(64, 768)), jitter_entry(32)),
                    pack_row(jitter_entry(128), jitter_entry(128), jitter_entry(128),
                             ENTRY_W'($urandom_range(128, 512))));
        run_random_boxes(320, 3, 0);

        // Perspective projection looking down negative z.
        load_matrix(pack_row(ENTRY_W'($urandom_range(128, 768)), jitter_entry(8), '0, '0),
                    pack_row(jitter_entry(8), ENTRY_W'($urandom_range(128, 768)), '0, '0),
                    pack_row(jitter_entry(8), jitter_entry(8),
                             ENTRY_W'(-int'($urandom_range(256, 320))), 16'hFF00),
                    pack_row(jitter_entry(16), jitter_entry(16),
                             ENTRY_W'(-int'($urandom_range(256, 1024))), '0));
        run_random_boxes(320, 8, -10);

        load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_random_boxes(320, 4, 0);
    endtask

    task automatic test_output_backpressure();
        load_matrix(ROW_ZERO_RESET, ROW_ONE_RESET, ROW_TWO_RESET, ROW_THREE_RESET);
        sender_gaps = 1'b0;
        hold_off_requests++;
        for (int n = 0; n < 50; n++)
            send_box(random_box(2, 0));
        sender_gaps = 1'b1;
        wait_idle();
    endtask

    initial
    begin : result_receiver
        int unsigned len;
        forever
        begin
            @(posedge clk);
            if (hold_off_served != hold_off_requests)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_served++;
            end
            else if (clock_count % 600 < 420 && $urandom_range(0, 99) < 25)
            begin
                len = 1 + pick_gap();
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_visible.size() == 0)
            begin
                $display("%0t: unexpected item, visible %b", $time, visible);
                mismatch_count++;
            end
            else
            begin
                wanted_visible = expected_visible.pop_front();
                if (visible !== wanted_visible)
                begin
                    $display("%0t: visible expected %b, actual %b", $time, wanted_visible,
                             visible);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #RUN_LIMIT;
        $display("%0t: run timed out", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        matrix_rows[REG_ROW_ZERO] = ROW_ZERO_RESET;
        matrix_rows[REG_ROW_ONE] = ROW_ONE_RESET;
        matrix_rows[REG_ROW_TWO] = ROW_TWO_RESET;
        matrix_rows[REG_ROW_THREE] = ROW_THREE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_identity();
        test_boundary_boxes();
        test_matrix_extremes();
        test_random_frusta();
        test_output_backpressure();

        if (mismatch_count == 0 && expected_visible.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> frustum_aabb_visibility_test_unit.f
hdl/fav_pkg.sv
hdl/fav_plane_cfg.sv
hdl/fav_mul_stage.sv
hdl/fav_sum_stage.sv
hdl/frustum_aabb_visibility_test_unit.sv
dv/tb_frustum_aabb_visibility_test_unit.sv
